FILE: rtl/tcf_pkg.sv
// Shared types, constants and helper functions of the tilt complementary filter.
package tcf_pkg;

    // Field and result widths
    localparam int SAMPLE_W  = 16;
    localparam int ANGLE_W   = 25;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;
    localparam int WEIGHT_W  = 16;
    localparam int GAIN_W    = 8;
    localparam int CFG_W     = 16;

    // CORDIC vector and binary-angle accumulator widths
    localparam int CORDIC_W  = 44;
    localparam int ZACC_W    = 34;
    localparam int ATAN_IDX_W = 5;
    localparam int WIDE_W    = 48;

    localparam logic signed [WIDE_W-1:0] ANGLE_MAX = 48'sd16777215;
    localparam logic signed [WIDE_W-1:0] ANGLE_MIN = -48'sd16777216;

    typedef enum logic [0:0] {
        REG_BLEND_WEIGHT = 1'b0,
        REG_GYRO_GAIN    = 1'b1
    } tcf_reg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                  load;
        logic                  iter;
        logic                  deg;
        logic                  scale;
        logic                  blend;
        logic                  fuse;
        logic [ATAN_IDX_W-1:0] idx;
    } tcf_cmd_t;

    // atan(2^-i) as a binary angle, 2^32 units per turn
    function automatic logic [30:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [30:0] a;
        case (idx)
            5'd0:    a = 31'd536870912;
            5'd1:    a = 31'd316933406;
            5'd2:    a = 31'd167458907;
            5'd3:    a = 31'd85004756;
            5'd4:    a = 31'd42667331;
            5'd5:    a = 31'd21354465;
            5'd6:    a = 31'd10679838;
            5'd7:    a = 31'd5340245;
            5'd8:    a = 31'd2670163;
            5'd9:    a = 31'd1335087;
            5'd10:   a = 31'd667544;
            5'd11:   a = 31'd333772;
            5'd12:   a = 31'd166886;
            5'd13:   a = 31'd83443;
            5'd14:   a = 31'd41722;
            5'd15:   a = 31'd20861;
            5'd16:   a = 31'd10430;
            5'd17:   a = 31'd5215;
            5'd18:   a = 31'd2608;
            5'd19:   a = 31'd1304;
            5'd20:   a = 31'd652;
            5'd21:   a = 31'd326;
            5'd22:   a = 31'd163;
            5'd23:   a = 31'd81;
            default: a = 31'd0;
        endcase
        return a;
    endfunction

    // Clamp to the signed 25-bit angle range
    function automatic logic signed [ANGLE_W-1:0] sat_angle(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] c;
        if (v > ANGLE_MAX) begin
            c = ANGLE_MAX;
        end else if (v < ANGLE_MIN) begin
            c = ANGLE_MIN;
        end else begin
            c = v;
        end
        return c[ANGLE_W-1:0];
    endfunction

endpackage

FILE: rtl/tcf_ctrl.sv
// Sequencing state machine: accept, CORDIC iterations, scaling, blend, result hand-off.
module tcf_ctrl import tcf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output tcf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_DEG,
        ST_SCALE,
        ST_BLEND,
        ST_FUSE
    } state_t;

    localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);

    state_t                state_reg, state_next;
    logic [ATAN_IDX_W-1:0] iter_reg, iter_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  fire;

    // Finish only when the output register is free or being emptied
    assign fire = (state_reg == ST_FUSE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                iter_next = '0;
                if (s_tvalid) begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (iter_reg == LAST_STEP) begin
                    state_next = ST_DEG;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_DEG:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_BLEND;
            ST_BLEND: state_next = ST_FUSE;
            ST_FUSE: begin
                if (fire) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    assign cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.iter  = (state_reg == ST_ITER);
    assign cmd.deg   = (state_reg == ST_DEG);
    assign cmd.scale = (state_reg == ST_SCALE);
    assign cmd.blend = (state_reg == ST_BLEND);
    assign cmd.fuse  = fire;
    assign cmd.idx   = iter_reg;

endmodule

FILE: rtl/tcf_datapath.sv
// Datapath: configuration registers, CORDIC vectoring unit, degree scaling and blend.
module tcf_datapath import tcf_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcf_cmd_t             cmd,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DEG_SH = 29 - ANGLE_FRAC_BITS;
    localparam logic [40:0] DEG_RND = 41'(1) << (28 - ANGLE_FRAC_BITS);

    logic [WEIGHT_W-1:0] blend_weight_reg;
    logic [GAIN_W-1:0]   gyro_gain_reg;

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ZACC_W-1:0]   z_reg, z_next;
    logic                       zero_reg;
    logic signed [SAMPLE_W-1:0] gy_reg;
    logic [39:0]                prod45_reg;
    logic                       neg_reg;
    logic signed [24:0]         gprod_reg;
    logic signed [ANGLE_W-1:0]  acc_reg, gyr_reg;
    logic signed [42:0]         blend_reg;
    logic signed [ANGLE_W-1:0]  fused_reg;
    logic signed [ANGLE_W-1:0]  tilt_out_reg, accel_out_reg, gyro_out_reg;

    logic signed [SAMPLE_W:0]   ax_s, az_s, xs, ys;
    logic signed [ZACC_W-1:0]   z_init;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ZACC_W-1:0]   atan_z;
    logic [ZACC_W-1:0]          mag;
    logic [40:0]                deg_sum;
    logic [40:0]                q;
    logic signed [WIDE_W-1:0]   acc_wide;
    logic signed [25:0]         diff;
    logic signed [42:0]         blend_rnd;
    logic signed [ANGLE_W-1:0]  fused;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_weight_reg <= WEIGHT_W'(66);
            gyro_gain_reg    <= GAIN_W'(4);
        end else if (cfg_we) begin
            case (tcf_reg_t'(cfg_addr))
                REG_BLEND_WEIGHT: blend_weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                REG_GYRO_GAIN:    gyro_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pre-rotate into the right half plane (x = acc_z, y = acc_x)
    always_comb begin
        ax_s   = $signed({s_tdata[15], s_tdata[15:0]});
        az_s   = $signed({s_tdata[31], s_tdata[31:16]});
        xs     = az_s;
        ys     = ax_s;
        z_init = '0;
        if (az_s < 0) begin
            if (ax_s >= 0) begin
                xs     = ax_s;
                ys     = -az_s;
                z_init = ZACC_W'(32'sd1073741824);
            end else begin
                xs     = -ax_s;
                ys     = az_s;
                z_init = -ZACC_W'(32'sd1073741824);
            end
        end
    end

    // One CORDIC micro-rotation per cycle
    assign dx     = y_reg >>> cmd.idx;
    assign dy     = x_reg >>> cmd.idx;
    assign atan_z = $signed({3'b000, atan_entry(cmd.idx)});

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.load) begin
            x_next = $signed({{(CORDIC_W-SAMPLE_W-25){xs[SAMPLE_W]}}, xs, 24'd0});
            y_next = $signed({{(CORDIC_W-SAMPLE_W-25){ys[SAMPLE_W]}}, ys, 24'd0});
            z_next = z_init;
        end else if (cmd.iter) begin
            if (y_reg > 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
        end
    end

    // Binary angle to degrees, rounded half away from zero
    assign mag     = z_reg[ZACC_W-1] ? ZACC_W'(-z_reg) : ZACC_W'(z_reg);
    assign deg_sum = {1'b0, prod45_reg} + DEG_RND;
    assign q       = deg_sum >> DEG_SH;

    always_comb begin
        acc_wide = $signed({7'd0, q});
        if (neg_reg) begin
            acc_wide = -acc_wide;
        end
        if (zero_reg) begin
            acc_wide = '0;
        end
    end

    // Blend: gyr + round(alpha * (acc - gyr)), ties toward plus infinity
    assign diff      = 26'(acc_reg) - 26'(gyr_reg);
    assign blend_rnd = (blend_reg + 43'sd32768) >>> 16;
    assign fused     = sat_angle(WIDE_W'(gyr_reg) + WIDE_W'(blend_rnd));

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.load) begin
            zero_reg <= (s_tdata[15:0] == '0) && (s_tdata[31:16] == '0);
            gy_reg   <= $signed(s_tdata[47:32]);
        end
        if (cmd.deg) begin
            prod45_reg <= 40'(mag) * 40'd45;
            neg_reg    <= (z_reg > 0);
            gprod_reg  <= gy_reg * $signed({1'b0, gyro_gain_reg});
        end
        if (cmd.scale) begin
            acc_reg <= sat_angle(acc_wide);
            gyr_reg <= sat_angle(WIDE_W'(fused_reg) + WIDE_W'(gprod_reg));
        end
        if (cmd.blend) begin
            blend_reg <= diff * $signed({1'b0, blend_weight_reg});
        end
        if (cmd.fuse) begin
            tilt_out_reg  <= fused;
            accel_out_reg <= acc_reg;
            gyro_out_reg  <= gyr_reg;
        end
    end

    // Kept angle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fused_reg <= '0;
        end else if (cmd.fuse) begin
            fused_reg <= fused;
        end
    end

    assign m_tdata = {5'd0, gyro_out_reg, accel_out_reg, tilt_out_reg};

endmodule

FILE: rtl/tilt_complementary_filter_unit.sv
// Top level of the tilt complementary filter: controller plus datapath.
//
//  channel  dir  ports                         payload (lowest bit up)
//  s_       in   s_tvalid/s_tready/s_tdata     acc_x[15:0] acc_z[31:16] gyro_y[47:32]
//  m_       out  m_tvalid/m_tready/m_tdata     tilt[24:0] accel[49:25] gyro[74:50]
//  cfg_     in   cfg_we/cfg_addr/cfg_wdata     0 blend_weight, 1 gyro_gain
//
// A sample passes through an accept step, the iterations of the shared CORDIC rotator,
// then scaling, gain, blend and write-back. One sample is in flight at a time; the
// output register holds the last result so the next sample is accepted while it
// waits. A stalled m_ side holds the block in its write-back cycle. Reset is
// synchronous, active low, and sets the kept angle to zero and the registers to
// their defaults.
module tilt_complementary_filter_unit import tcf_pkg::*; #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // acc_x, acc_z, gyro_y
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // tilt_angle, accel_angle, gyro_angle, pad
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    tcf_cmd_t cmd;

    tcf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    tcf_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/tcf_checker.sv
// Port-level checker for the tilt complementary filter, bound to the top level.
module tcf_checker import tcf_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // One sample in flight: no accept in the cycle after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Pad bits above the three angles stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:3*ANGLE_W] == '0)
        else $error("nonzero pad bits in result");

endmodule

bind tilt_complementary_filter_unit tcf_checker u_tcf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
